// ===== rtl/cht_pkg.sv =====
// shared types and constants for the chained hash table
package cht_pkg;

  localparam int KEY_W = 31;
  localparam int MOD_W = 8;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_POS   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [31:0]      NONE_KEY         = 32'hFFFF_FFFF;
  localparam logic [MOD_W-1:0] BUCKET_COUNT_RST = 8'd100;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
    logic [6:0]       bucket_index;
    logic [3:0]       entry_position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_key;
    logic [3:0]         bucket_fill;
  } out_item_t;

endpackage

// ===== rtl/chained_hash_table.sv =====
// chained hash table: insert/search run the remainder unit on the key, then scan the
// bucket slot by slot (a read state and a compare state per slot) over one memory read port;
// read entry reads the fill count, then the entry; clear runs the fill count sweep
// one item at a time; in_ready is high only while idle
// after reset the fill counts are swept to zero before the first item is taken;
// bucket_count resets to 100
module chained_hash_table #(
  parameter int NUM_BUCKETS  = 128,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cht_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cht_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [cht_pkg::MOD_W-1:0]   cfg_data
);

  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int SLOT_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int ENTRIES = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int EA_W    = $clog2(ENTRIES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_FILL_RD, S_FILL_USE, S_SCAN_RD, S_SCAN_CMP,
    S_ENTRY_RD, S_ENTRY_USE, S_WRITE, S_REPLY
  } state_t;

  state_t                      state;
  logic [1:0]                  req;
  logic [cht_pkg::KEY_W-1:0]   key;
  logic [3:0]                  pos;
  logic [BKT_W-1:0]            bucket;
  logic [BKT_W-1:0]            sweep;
  logic [SLOT_W-1:0]           slot;
  logic [SLOT_W-1:0]           fill;
  logic                        clr_reply;
  cht_pkg::out_item_t          res;
  logic [cht_pkg::MOD_W-1:0]   bucket_count;
  logic [cht_pkg::MOD_W-1:0]   modv;

  logic [SLOT_W-1:0]           fill_mem [NUM_BUCKETS];
  logic [SLOT_W-1:0]           fill_rdata;
  logic                        fill_we;
  logic [BKT_W-1:0]            fill_waddr;
  logic [SLOT_W-1:0]           fill_wdata;

  logic [cht_pkg::KEY_W-1:0]   entry_mem [ENTRIES];
  logic [cht_pkg::KEY_W-1:0]   entry_rdata;
  logic [EA_W-1:0]             entry_addr;
  logic                        entry_we;

  logic                        accept;
  logic                        div_start;
  logic                        div_done;
  logic [cht_pkg::MOD_W-1:0]   div_rem;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // modulus of 0 acts as 1, above the table size acts as the table size
  always_comb begin
    if (bucket_count == '0) begin
      modv = cht_pkg::MOD_W'(1);
    end else if (32'(bucket_count) > NUM_BUCKETS) begin
      modv = cht_pkg::MOD_W'(NUM_BUCKETS);
    end else begin
      modv = bucket_count;
    end
  end

  assign div_start = accept && (in_item.req_type == cht_pkg::REQ_INSERT ||
                                in_item.req_type == cht_pkg::REQ_SEARCH);

  cht_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (in_item.key),
    .divisor   (modv),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= cht_pkg::BUCKET_COUNT_RST;
    end else if (cfg_we) begin
      bucket_count <= cfg_data;
    end
  end

  // after a failed scan slot equals the fill count, which is the append position
  assign entry_addr = EA_W'(bucket) * EA_W'(BUCKET_DEPTH) + EA_W'(slot);
  assign entry_we   = (state == S_WRITE);

  assign fill_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign fill_waddr = (state == S_CLEAR) ? sweep : bucket;
  assign fill_wdata = (state == S_CLEAR) ? '0 : fill + 1'b1;

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_rdata <= fill_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[entry_addr] <= key;
    end
    entry_rdata <= entry_mem[entry_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep     <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a reply state that hands over a new item keeps out_valid high itself
      if (out_valid && out_ready && state != S_REPLY) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == BKT_W'(NUM_BUCKETS - 1)) begin
            state <= clr_reply ? S_REPLY : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req <= in_item.req_type;
            key <= in_item.key;
            pos <= in_item.entry_position;
            unique case (in_item.req_type) inside
              cht_pkg::REQ_INSERT, cht_pkg::REQ_SEARCH: begin
                state <= S_DIV;
              end
              cht_pkg::REQ_READ: begin
                if (32'(in_item.bucket_index) >= NUM_BUCKETS) begin
                  res   <= '{cht_pkg::ST_BAD_POS, cht_pkg::NONE_KEY, 4'd0};
                  state <= S_REPLY;
                end else begin
                  bucket <= BKT_W'(in_item.bucket_index);
                  state  <= S_FILL_RD;
                end
              end
              cht_pkg::REQ_CLEAR: begin
                sweep     <= '0;
                clr_reply <= 1'b1;
                res       <= '{cht_pkg::ST_OK, cht_pkg::NONE_KEY, 4'd0};
                state     <= S_CLEAR;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            bucket <= BKT_W'(div_rem);
            state  <= S_FILL_RD;
          end
        end
        S_FILL_RD: begin
          state <= S_FILL_USE;
        end
        S_FILL_USE: begin
          fill <= fill_rdata;
          if (req == cht_pkg::REQ_READ) begin
            if (pos == 4'd0 || 32'(pos) > 32'(fill_rdata) || 32'(pos) > BUCKET_DEPTH) begin
              res   <= '{cht_pkg::ST_BAD_POS, cht_pkg::NONE_KEY, 4'(fill_rdata)};
              state <= S_REPLY;
            end else begin
              slot  <= SLOT_W'(pos - 4'd1);
              state <= S_ENTRY_RD;
            end
          end else begin
            slot  <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (slot == fill) begin
            if (req == cht_pkg::REQ_SEARCH) begin
              res   <= '{cht_pkg::ST_NOT_FOUND, cht_pkg::NONE_KEY, 4'(fill)};
              state <= S_REPLY;
            end else if (32'(fill) >= BUCKET_DEPTH) begin
              res   <= '{cht_pkg::ST_FULL, cht_pkg::NONE_KEY, 4'(fill)};
              state <= S_REPLY;
            end else begin
              state <= S_WRITE;
            end
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (entry_rdata == key) begin
            res <= '{(req == cht_pkg::REQ_INSERT) ? cht_pkg::ST_DUPLICATE : cht_pkg::ST_OK,
                     {1'b0, key}, 4'(fill)};
            state <= S_REPLY;
          end else begin
            slot  <= slot + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_WRITE: begin
          res   <= '{cht_pkg::ST_OK, {1'b0, key}, 4'(fill + 1'b1)};
          state <= S_REPLY;
        end
        S_ENTRY_RD: begin
          state <= S_ENTRY_USE;
        end
        S_ENTRY_USE: begin
          res   <= '{cht_pkg::ST_OK, {1'b0, entry_rdata}, 4'(fill)};
          state <= S_REPLY;
        end
        S_REPLY: begin
          if (!out_valid || out_ready) begin
            out_item  <= res;
            out_valid <= 1'b1;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("remainder unit finished outside the hashing step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken again right after an item");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL_USE |-> 32'(fill_rdata) <= BUCKET_DEPTH)
    else $error("bucket fill count above bucket depth");

  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> 32'(fill) < BUCKET_DEPTH && slot == fill)
    else $error("append into a full bucket or at a wrong slot");

endmodule

// ===== rtl/cht_divider.sv =====
// iterative restoring remainder unit, one key bit per cycle
module cht_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cht_pkg::KEY_W-1:0]   dividend,
  input  logic [cht_pkg::MOD_W-1:0]   divisor,
  output logic                        done,
  output logic [cht_pkg::MOD_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(cht_pkg::KEY_W);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [cht_pkg::KEY_W-1:0]   dvd;
  logic [cht_pkg::MOD_W-1:0]   dsr;
  logic [cht_pkg::MOD_W:0]     trial;

  // partial remainder stays below the divisor, so trial fits one extra bit
  assign trial = {remainder, dvd[cht_pkg::KEY_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        dvd       <= dividend;
        dsr       <= divisor;
        remainder <= '0;
        cnt       <= CNT_W'(cht_pkg::KEY_W - 1);
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          remainder <= cht_pkg::MOD_W'(trial - {1'b0, dsr});
        end else begin
          remainder <= trial[cht_pkg::MOD_W-1:0];
        end
        dvd <= {dvd[cht_pkg::KEY_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
